/* sv/wsp_pkg.sv */
// wsp_pkg: shared types and constants for the wav stream to pcm16 block
// no dependencies; imported by every module of the block
package wsp_pkg;

  // riff chunk tags, little-endian byte order
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // format tags
  localparam logic [15:0] FMT_PCM        = 16'h0001;
  localparam logic [15:0] FMT_FLOAT      = 16'h0003;
  localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;

  localparam logic [31:0] MIN_FILE_BYTES = 32'd44;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SHORT   = 3'd1;
  localparam logic [2:0] ST_TAGS    = 3'd2;
  localparam logic [2:0] ST_NO_DATA = 3'd3;
  localparam logic [2:0] ST_CHANS   = 3'd4;
  localparam logic [2:0] ST_FORMAT  = 3'd5;
  localparam logic [2:0] ST_BITS    = 3'd6;
  localparam logic [2:0] ST_ORDER   = 3'd7;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // what the parser hands on for one input beat
  typedef struct packed {
    logic        has_sample;
    logic [31:0] sample_raw;
    logic [2:0]  width;
    logic        is_float;
    logic        has_status;
    logic [2:0]  code;
    logic [31:0] rate;
    logic [15:0] chans;
  } parse_item_t;

  // one queue entry: a sample, a status, or both
  typedef struct packed {
    logic        valid;
    logic        has_sample;
    logic [15:0] pcm;
    logic        has_status;
    logic [2:0]  code;
    logic [31:0] rate;
    logic [15:0] chans;
  } result_entry_t;

endpackage

/* sv/wav_stream_to_pcm16.sv */
// wav_stream_to_pcm16: top level, parser, converter pipeline and result queue
// depends on wsp_pkg, wsp_parser, wsp_conv, wsp_out_fifo
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------------
//  in      | in_valid, in_stall  | data_byte, end_of_file
//  out     | out_valid, out_stall| pcm_sample, status_code, rate_hz,
//          |                     | channel_count, is_status
//
// one byte is taken per cycle while in_stall is low; its result is decoded by the parser
// combinationally, then passes the multiply stage, the round stage and the queue.
// the eof byte yields a sample beat (if one completes) then a status beat.
// in_stall rises when the queue plus the two pipeline stages would exceed
// the eight queue entries; reset (rst, synchronous) empties everything.
module wav_stream_to_pcm16 (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               end_of_file,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] pcm_sample,
  output logic [2:0]         status_code,
  output logic [31:0]        rate_hz,
  output logic [15:0]        channel_count,
  output logic               is_status
);
  import wsp_pkg::*;

  parse_item_t      item;
  result_entry_t    res, head;
  logic             stage_a_valid;
  logic [CNT_W-1:0] count;
  logic [CNT_W:0]   occupancy;
  logic             accept, out_beat, show_sample, pop, sent;

  // room check covers beats still in the pipeline
  assign occupancy = {1'b0, count} + (CNT_W + 1)'(stage_a_valid) + (CNT_W + 1)'(res.valid);
  assign in_stall  = occupancy >= (CNT_W + 1)'(FIFO_DEPTH);
  assign accept    = in_valid && !in_stall;

  wsp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .end_of_file (end_of_file),
    .item        (item)
  );

  wsp_conv u_conv (
    .clk           (clk),
    .rst           (rst),
    .load          (accept),
    .item          (item),
    .stage_a_valid (stage_a_valid),
    .res           (res)
  );

  wsp_out_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_entry (res),
    .pop      (pop),
    .head     (head),
    .count    (count)
  );

  // head entry: sample beat first, then status beat
  assign out_valid     = (count != '0);
  assign show_sample   = head.has_sample && !sent;
  assign out_beat      = out_valid && !out_stall;
  assign pop           = out_beat && (!show_sample || !head.has_status);
  assign pcm_sample    = show_sample ? head.pcm : 16'd0;
  assign status_code   = show_sample ? ST_OK : head.code;
  assign rate_hz       = show_sample ? 32'd0 : head.rate;
  assign channel_count = show_sample ? 16'd0 : head.chans;
  assign is_status     = !show_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      sent <= 1'b0;
    end else if (out_beat) begin
      sent <= !pop;
    end
  end

endmodule

/* sv/wsp_parser.sv */
// wsp_parser: riff/wave chunk walker, fmt field capture and sample assembly
// depends on wsp_pkg
module wsp_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_file,
  output wsp_pkg::parse_item_t item
);
  import wsp_pkg::*;

  typedef enum logic [2:0] {
    PH_RIFF = 3'd0,
    PH_HEAD = 3'd1,
    PH_SKIP = 3'd2,
    PH_FMT  = 3'd3,
    PH_DATA = 3'd4,
    PH_PAD  = 3'd5
  } phase_t;

  phase_t      phase, phase_next, hp;
  logic [31:0] total_bytes, total_bytes_next;
  logic        tags_ok, tags_ok_next;
  logic [31:0] chunk_tag, chunk_tag_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] chunk_position, chunk_position_next;
  logic [15:0] format_tag, format_tag_next;
  logic [15:0] channels_seen, channels_seen_next;
  logic [15:0] bits_per_sample, bits_per_sample_next;
  logic [31:0] rate_seen, rate_seen_next;
  logic        fmt_done, fmt_done_next;
  logic        data_done, data_done_next;
  logic [31:0] sample_bytes, sample_bytes_next;
  logic [1:0]  sample_byte_index, sample_byte_index_next;
  logic        order_error, order_error_next;

  logic        do_head;
  logic [2:0]  w;
  logic [2:0]  w_end;
  logic [31:0] sb;
  logic [31:0] tag_n, len_n;
  logic [31:0] byte_wide;

  // bytes per sample of a supported format, else 0
  function automatic logic [2:0] width_of(input logic [15:0] ft, input logic [15:0] bps);
    logic [2:0] r;
    r = 3'd0;
    if (ft == FMT_FLOAT && bps == 16'd32) r = 3'd4;
    else if (ft == FMT_PCM) begin
      case (bps)
        16'd8:   r = 3'd1;
        16'd16:  r = 3'd2;
        16'd24:  r = 3'd3;
        16'd32:  r = 3'd4;
        default: r = 3'd0;
      endcase
    end
    return r;
  endfunction

  assign byte_wide = {24'd0, data_byte};
  assign w         = width_of(format_tag, bits_per_sample);

  // next state for one accepted beat
  always_comb begin
    phase_next             = phase;
    total_bytes_next       = (total_bytes == 32'hFFFF_FFFF) ? total_bytes : total_bytes + 32'd1;
    tags_ok_next           = tags_ok;
    chunk_tag_next         = chunk_tag;
    chunk_length_next      = chunk_length;
    chunk_position_next    = chunk_position;
    format_tag_next        = format_tag;
    channels_seen_next     = channels_seen;
    bits_per_sample_next   = bits_per_sample;
    rate_seen_next         = rate_seen;
    fmt_done_next          = fmt_done;
    data_done_next         = data_done;
    sample_bytes_next      = sample_bytes;
    sample_byte_index_next = sample_byte_index;
    order_error_next       = order_error;
    item                   = '0;
    do_head                = 1'b0;
    sb                     = '0;
    tag_n                  = '0;
    len_n                  = '0;
    hp                     = PH_SKIP;
    w_end                  = '0;

    unique case (phase)
      PH_RIFF: begin
        chunk_tag_next = {data_byte, chunk_tag[31:8]};
        if (chunk_position == 32'd3 && chunk_tag_next != TAG_RIFF) tags_ok_next = 1'b0;
        if (chunk_position == 32'd11 && chunk_tag_next != TAG_WAVE) tags_ok_next = 1'b0;
        chunk_position_next = chunk_position + 32'd1;
        if (chunk_position_next >= 32'd12) begin
          chunk_position_next = '0;
          chunk_tag_next      = '0;
          phase_next          = PH_HEAD;
        end
      end
      PH_SKIP, PH_FMT, PH_DATA: begin
        // fmt body fields
        if (phase == PH_FMT) begin
          if (chunk_position == 32'd0) format_tag_next = {8'd0, data_byte};
          else if (chunk_position == 32'd1) format_tag_next = {data_byte, format_tag[7:0]};
          else if (chunk_position == 32'd2) channels_seen_next = {8'd0, data_byte};
          else if (chunk_position == 32'd3) channels_seen_next = {data_byte, channels_seen[7:0]};
          else if (chunk_position == 32'd4) rate_seen_next = byte_wide;
          else if (chunk_position == 32'd5) rate_seen_next = rate_seen | (byte_wide << 8);
          else if (chunk_position == 32'd6) rate_seen_next = rate_seen | (byte_wide << 16);
          else if (chunk_position == 32'd7) rate_seen_next = rate_seen | (byte_wide << 24);
          else if (chunk_position == 32'd14) bits_per_sample_next = {8'd0, data_byte};
          else if (chunk_position == 32'd15)
            bits_per_sample_next = {data_byte, bits_per_sample[7:0]};
          else if (chunk_length >= 32'd40 && chunk_position == 32'd24)
            sample_bytes_next = byte_wide;
          else if (chunk_length >= 32'd40 && chunk_position == 32'd25 &&
                   format_tag == FMT_EXTENSIBLE)
            format_tag_next = {data_byte, sample_bytes[7:0]};
        end
        // sample assembly
        if (phase == PH_DATA && w != 3'd0) begin
          sb    = sample_bytes | (byte_wide << {sample_byte_index, 3'b000});
          w_end = {1'b0, sample_byte_index} + 3'd1;
          if (w_end == w) begin
            item.has_sample        = 1'b1;
            item.sample_raw        = sb;
            item.width             = w;
            item.is_float          = (format_tag == FMT_FLOAT);
            sample_bytes_next      = '0;
            sample_byte_index_next = '0;
          end else begin
            sample_bytes_next      = sb;
            sample_byte_index_next = sample_byte_index + 2'd1;
          end
        end
        chunk_position_next = chunk_position + 32'd1;
        if (chunk_position_next >= chunk_length) begin
          if (phase == PH_DATA) data_done_next = 1'b1;
          if (phase == PH_FMT) fmt_done_next = 1'b1;
          chunk_position_next = '0;
          phase_next          = chunk_length[0] ? PH_PAD : PH_HEAD;
        end
      end
      PH_PAD: begin
        chunk_position_next = '0;
        phase_next          = PH_HEAD;
      end
      PH_HEAD: begin
        do_head = 1'b1;
      end
      default: begin
        do_head = 1'b1;
      end
    endcase

    // chunk header: tag then length
    if (do_head) begin
      tag_n = (chunk_position == 32'd0) ? 32'd0 : chunk_tag;
      len_n = (chunk_position == 32'd0) ? 32'd0 : chunk_length;
      if (chunk_position < 32'd4) tag_n = tag_n | (byte_wide << {chunk_position[1:0], 3'b000});
      else len_n = len_n | (byte_wide << {chunk_position[1:0], 3'b000});
      chunk_tag_next    = tag_n;
      chunk_length_next = len_n;
      if (chunk_position < 32'd7) begin
        chunk_position_next = chunk_position + 32'd1;
      end else begin
        chunk_position_next = '0;
        if (tag_n == TAG_DATA) begin
          if (data_done || !fmt_done) begin
            order_error_next = 1'b1;
            hp               = PH_SKIP;
          end else begin
            hp                     = PH_DATA;
            sample_bytes_next      = '0;
            sample_byte_index_next = '0;
          end
        end else if (tag_n == TAG_FMT && len_n >= 32'd16 && !data_done) begin
          hp                = PH_FMT;
          sample_bytes_next = '0;
        end else begin
          hp = PH_SKIP;
        end
        phase_next = hp;
        // empty chunk ends at once
        if (len_n == 32'd0) begin
          if (hp == PH_DATA) data_done_next = 1'b1;
          if (hp == PH_FMT) fmt_done_next = 1'b1;
          phase_next = PH_HEAD;
        end
      end
    end

    // final status, then back to reset
    if (end_of_file) begin
      item.has_status = 1'b1;
      item.rate       = rate_seen_next;
      item.chans      = channels_seen_next;
      if (total_bytes_next < MIN_FILE_BYTES) item.code = ST_SHORT;
      else if (!tags_ok_next) item.code = ST_TAGS;
      else if (order_error_next) item.code = ST_ORDER;
      else if (!data_done_next) item.code = ST_NO_DATA;
      else if (channels_seen_next != 16'd1 && channels_seen_next != 16'd2) item.code = ST_CHANS;
      else if (format_tag_next != FMT_PCM && format_tag_next != FMT_FLOAT) item.code = ST_FORMAT;
      else if (width_of(format_tag_next, bits_per_sample_next) == 3'd0) item.code = ST_BITS;
      else item.code = ST_OK;
      phase_next             = PH_RIFF;
      total_bytes_next       = '0;
      tags_ok_next           = 1'b1;
      chunk_tag_next         = '0;
      chunk_length_next      = '0;
      chunk_position_next    = '0;
      format_tag_next        = '0;
      channels_seen_next     = '0;
      bits_per_sample_next   = '0;
      rate_seen_next         = '0;
      fmt_done_next          = 1'b0;
      data_done_next         = 1'b0;
      sample_bytes_next      = '0;
      sample_byte_index_next = '0;
      order_error_next       = 1'b0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_RIFF;
      total_bytes       <= '0;
      tags_ok           <= 1'b1;
      chunk_tag         <= '0;
      chunk_length      <= '0;
      chunk_position    <= '0;
      format_tag        <= '0;
      channels_seen     <= '0;
      bits_per_sample   <= '0;
      rate_seen         <= '0;
      fmt_done          <= 1'b0;
      data_done         <= 1'b0;
      sample_bytes      <= '0;
      sample_byte_index <= '0;
      order_error       <= 1'b0;
    end else if (accept) begin
      phase             <= phase_next;
      total_bytes       <= total_bytes_next;
      tags_ok           <= tags_ok_next;
      chunk_tag         <= chunk_tag_next;
      chunk_length      <= chunk_length_next;
      chunk_position    <= chunk_position_next;
      format_tag        <= format_tag_next;
      channels_seen     <= channels_seen_next;
      bits_per_sample   <= bits_per_sample_next;
      rate_seen         <= rate_seen_next;
      fmt_done          <= fmt_done_next;
      data_done         <= data_done_next;
      sample_bytes      <= sample_bytes_next;
      sample_byte_index <= sample_byte_index_next;
      order_error       <= order_error_next;
    end
  end

endmodule

/* sv/wsp_conv.sv */
// wsp_conv: two-stage sample converter, multiply stage then round and clamp stage
// depends on wsp_pkg
module wsp_conv (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  wsp_pkg::parse_item_t   item,
  output logic                   stage_a_valid,
  output wsp_pkg::result_entry_t res
);
  import wsp_pkg::*;

  // stage a registers
  logic              a_has_sample, a_has_status, a_float, a_sign, a_zero, a_inf;
  logic [2:0]        a_code;
  logic [31:0]       a_rate;
  logic [15:0]       a_chans;
  logic [15:0]       a_int_pcm;
  logic [38:0]       a_prod;
  logic signed [9:0] a_ex;

  logic [7:0]        e;
  logic [22:0]       m;
  logic [23:0]       mant;
  logic [15:0]       int_pcm;

  // integer forms and float fields
  always_comb begin
    e    = item.sample_raw[30:23];
    m    = item.sample_raw[22:0];
    mant = (e != 8'd0) ? {1'b1, m} : {1'b0, m};
    case (item.width)
      3'd1:    int_pcm = {~item.sample_raw[7], item.sample_raw[6:0], 8'd0};
      3'd2:    int_pcm = item.sample_raw[15:0];
      3'd3:    int_pcm = item.sample_raw[23:8];
      default: int_pcm = item.sample_raw[31:16];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_a_valid <= 1'b0;
    end else begin
      stage_a_valid <= load && (item.has_sample || item.has_status);
    end
    a_has_sample <= item.has_sample;
    a_has_status <= item.has_status;
    a_code       <= item.code;
    a_rate       <= item.rate;
    a_chans      <= item.chans;
    a_float      <= item.is_float;
    a_int_pcm    <= int_pcm;
    a_sign       <= item.sample_raw[31];
    a_zero       <= (e == 8'hFF && m != 23'd0) || (e == 8'd0 && m == 23'd0);
    a_inf        <= (e == 8'hFF && m == 23'd0);
    a_prod       <= 39'(mant) * 39'(15'd32767);
    a_ex         <= (e != 8'd0) ? ($signed({2'b00, e}) - 10'sd150) : -10'sd149;
  end

  // stage b: round product to 24 bits, scale, clamp, truncate
  logic [5:0]        plen;
  logic [3:0]        sh;
  logic [38:0]       mask, rem, half;
  logic [24:0]       q0, q, qs;
  logic              rnd;
  logic signed [9:0] exs, nsh;
  logic [45:0]       wide;
  logic [16:0]       t, tt;
  logic [15:0]       fpcm;

  always_comb begin
    plen = '0;
    for (int i = 0; i < 39; i++) begin
      if (a_prod[i]) plen = 6'(i + 1);
    end
    sh   = (plen > 6'd24) ? 4'(plen - 6'd24) : 4'd0;
    q0   = 25'(a_prod >> sh);
    mask = (39'd1 << sh) - 39'd1;
    rem  = a_prod & mask;
    half = (sh != 4'd0) ? (39'd1 << (sh - 4'd1)) : 39'd0;
    rnd  = (sh != 4'd0) && ((rem > half) || (rem == half && q0[0]));
    q    = q0 + {24'd0, rnd};
    exs  = a_ex + $signed({6'd0, sh});
    nsh  = -exs;
    wide = '0;
    qs   = '0;
    if (a_inf) begin
      t = 17'd65536;
    end else if (exs >= 10'sd0) begin
      if (exs > 10'sd20) begin
        t = 17'd65536;
      end else begin
        wide = 46'(q) << exs[4:0];
        t    = (wide > 46'd65536) ? 17'd65536 : wide[16:0];
      end
    end else if (nsh >= 10'sd25) begin
      t = 17'd0;
    end else begin
      // right shift can still leave a value far above full scale
      qs = q >> nsh[4:0];
      t  = (qs > 25'd65536) ? 17'd65536 : qs[16:0];
    end
    if (a_sign) begin
      tt   = (t > 17'd32768) ? 17'd32768 : t;
      fpcm = 16'(17'd0 - tt);
    end else begin
      tt   = (t > 17'd32767) ? 17'd32767 : t;
      fpcm = tt[15:0];
    end
    if (a_zero) fpcm = 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= stage_a_valid;
    end
    res.has_sample <= a_has_sample;
    res.pcm        <= a_float ? fpcm : a_int_pcm;
    res.has_status <= a_has_status;
    res.code       <= a_code;
    res.rate       <= a_rate;
    res.chans      <= a_chans;
  end

endmodule

/* sv/wsp_out_fifo.sv */
// wsp_out_fifo: small result queue, one entry per beat that has results
// depends on wsp_pkg
module wsp_out_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  wsp_pkg::result_entry_t        wr_entry,
  input  logic                          pop,
  output wsp_pkg::result_entry_t        head,
  output logic [wsp_pkg::CNT_W-1:0]     count
);
  import wsp_pkg::*;

  result_entry_t entries [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;

  assign head = entries[rd_ptr];

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_entry.valid) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + CNT_W'(wr_entry.valid) - CNT_W'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_entry.valid) entries[wr_ptr] <= wr_entry;
  end

endmodule

/* verif/tb_top.sv */
// tb_top: self-checking testbench for wav_stream_to_pcm16
// depends on wsp_pkg and the wav_stream_to_pcm16 rtl; builds wav files byte by byte
// and checks every output beat against a local model of the parser and converter
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wsp_pkg::*;

  localparam int N_ITEMS   = 850;
  localparam int WDOG_MAX  = 5000;
  localparam int HOLD_LEN  = 200;
  localparam int HOLD_AT   = 300;
  localparam int MAX_SHOWN = 10;

  typedef enum logic [2:0] {
    PH_RIFF, PH_HEAD, PH_SKIP, PH_FMT, PH_DATA, PH_PAD
  } phase_t;

  typedef enum int {
    K_PCM8, K_PCM16, K_PCM24, K_PCM32, K_FLOAT, K_EXT, K_DATA_FIRST, K_DATA_TWICE,
    K_FMT_LATE, K_FMT_SHORT, K_TRUNC, K_BAD_TAGS, K_PAD_PARTIAL, K_BAD_FIELDS,
    K_NOISE, K_NUM_KINDS
  } file_kind_t;

  typedef struct {
    logic [15:0] pcm;
    logic [2:0]  code;
    logic [31:0] rate;
    logic [15:0] chans;
    logic        st;
  } beat_t;

  typedef struct {
    logic [7:0] b;
    logic       eof;
    logic       typed;
    beat_t      exp_beat;
  } byte_item_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         data_byte;
  logic               end_of_file;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] pcm_sample;
  logic [2:0]         status_code;
  logic [31:0]        rate_hz;
  logic [15:0]        channel_count;
  logic               is_status;

  beat_t      expected_beats[$];
  byte_item_t file_bytes[$];
  logic       row_typed;
  beat_t      row_beat;
  int         mismatches;
  int         idle_cycles;
  int         sent_count;
  bit         hold_req;
  bit         hold_done;

  // parser model state
  phase_t      m_phase;
  int unsigned m_total, m_tag, m_len, m_pos, m_fmt, m_chans, m_bits, m_rate;
  int unsigned m_sbytes, m_sidx;
  bit          m_tags_ok, m_fmt_done, m_data_done, m_order_err;

  wav_stream_to_pcm16 u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .end_of_file(end_of_file),
    .out_valid(out_valid), .out_stall(out_stall),
    .pcm_sample(pcm_sample), .status_code(status_code), .rate_hz(rate_hz),
    .channel_count(channel_count), .is_status(is_status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic parser_clear();
    m_phase = PH_RIFF;
    m_total = 0; m_tag = 0; m_len = 0; m_pos = 0; m_fmt = 0; m_chans = 0;
    m_bits = 0; m_rate = 0; m_sbytes = 0; m_sidx = 0;
    m_tags_ok = 1'b1; m_fmt_done = 1'b0; m_data_done = 1'b0; m_order_err = 1'b0;
  endtask

  function automatic int unsigned model_width();
    if (m_fmt == FMT_FLOAT && m_bits == 32) return 4;
    if (m_fmt == FMT_PCM && (m_bits == 8 || m_bits == 16 || m_bits == 24 || m_bits == 32))
      return m_bits / 8;
    return 0;
  endfunction

  // float32 times 32767, rounded to single, clamped and truncated toward zero
  function automatic logic [15:0] float_to_pcm16(logic [31:0] w);
    logic [7:0]       e;
    logic [22:0]      m;
    longint unsigned  mant, p, q, t, rem, half;
    int               ex;
    int unsigned      len, sh, n;
    e = w[30:23];
    m = w[22:0];
    len = 0;
    sh = 0;
    if (e == 8'hFF && m != 0) return 16'h0;
    if (e == 8'h00 && m == 0) return 16'h0;
    if (e == 8'hFF) begin
      t = 65536;
    end else begin
      mant = (e != 0) ? longint'({1'b1, m}) : longint'(m);
      ex = (e != 0) ? int'(e) - 150 : -149;
      p = mant * 32767;
      while (len < 64 && (p >> len) != 0) len++;
      q = p;
      if (len > 24) begin
        sh = len - 24;
        rem = p & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        q = p >> sh;
        if (rem > half || (rem == half && q[0])) q++;
      end
      ex += int'(sh);
      if (ex >= 0) begin
        t = (ex > 20) ? 65536 : (q << ex);
      end else begin
        n = -ex;
        t = (n >= 63) ? 0 : (q >> n);
      end
    end
    if (w[31]) begin
      if (t > 32768) t = 32768;
      return 16'(0 - t);
    end
    if (t > 32767) t = 32767;
    return t[15:0];
  endfunction

  function automatic logic [15:0] sample_to_pcm16(int unsigned nbytes);
    if (m_fmt == FMT_FLOAT) return float_to_pcm16(m_sbytes);
    case (nbytes)
      1: return {m_sbytes[7:0] ^ 8'h80, 8'h00};
      2: return m_sbytes[15:0];
      3: return m_sbytes[23:8];
      default: return m_sbytes[31:16];
    endcase
  endfunction

  task automatic body_done();
    if (m_phase == PH_DATA) m_data_done = 1'b1;
    if (m_phase == PH_FMT) m_fmt_done = 1'b1;
    m_pos = 0;
    m_phase = m_len[0] ? PH_PAD : PH_HEAD;
  endtask

  task automatic fmt_field_byte(int unsigned p, int unsigned b);
    if (p == 0) m_fmt = b;
    else if (p == 1) m_fmt |= b << 8;
    else if (p == 2) m_chans = b;
    else if (p == 3) m_chans |= b << 8;
    else if (p >= 4 && p <= 7) begin
      if (p == 4) m_rate = 0;
      m_rate |= b << (8 * (p - 4));
    end else if (p == 14) m_bits = b;
    else if (p == 15) m_bits |= b << 8;
    else if (m_len >= 40 && p == 24) m_sbytes = b;
    else if (m_len >= 40 && p == 25 && m_fmt == FMT_EXTENSIBLE)
      m_fmt = m_sbytes | (b << 8);
  endtask

  task automatic chunk_header_byte(int unsigned b);
    int unsigned p;
    p = m_pos;
    if (p == 0) begin
      m_tag = 0;
      m_len = 0;
    end
    if (p < 4) m_tag |= b << (8 * p);
    else m_len |= b << (8 * (p - 4));
    if (p < 7) begin
      m_pos = p + 1;
    end else begin
      m_pos = 0;
      if (m_tag == TAG_DATA) begin
        if (m_data_done || !m_fmt_done) begin
          m_order_err = 1'b1;
          m_phase = PH_SKIP;
        end else begin
          m_phase = PH_DATA;
          m_sbytes = 0;
          m_sidx = 0;
        end
      end else if (m_tag == TAG_FMT && m_len >= 16 && !m_data_done) begin
        m_phase = PH_FMT;
        m_sbytes = 0;
      end else begin
        m_phase = PH_SKIP;
      end
      if (m_len == 0) body_done();
    end
  endtask

  // advance the model by one byte and queue the beats it produces
  task automatic parse_wav_byte(logic [7:0] b, logic eof);
    int unsigned w;
    beat_t       r;
    if (m_total != 32'hFFFF_FFFF) m_total++;
    case (m_phase)
      PH_RIFF: begin
        m_tag = (m_tag >> 8) | (int'(b) << 24);
        if (m_pos == 3 && m_tag != TAG_RIFF) m_tags_ok = 1'b0;
        if (m_pos == 11 && m_tag != TAG_WAVE) m_tags_ok = 1'b0;
        m_pos++;
        if (m_pos >= 12) begin
          m_pos = 0;
          m_tag = 0;
          m_phase = PH_HEAD;
        end
      end
      PH_SKIP, PH_FMT, PH_DATA: begin
        if (m_phase == PH_FMT) begin
          fmt_field_byte(m_pos, 32'(b));
        end else if (m_phase == PH_DATA) begin
          w = model_width();
          if (w != 0) begin
            m_sbytes |= int'(b) << (8 * (m_sidx & 3));
            if (m_sidx + 1 == w) begin
              r = '{pcm: sample_to_pcm16(w), code: ST_OK, rate: 0, chans: 0, st: 1'b0};
              expected_beats.insert(expected_beats.size(), r);
              m_sbytes = 0;
              m_sidx = 0;
            end else begin
              m_sidx = (m_sidx + 1) & 3;
            end
          end
        end
        m_pos++;
        if (m_pos >= m_len) body_done();
      end
      PH_PAD: begin
        m_pos = 0;
        m_phase = PH_HEAD;
      end
      default: chunk_header_byte(32'(b));
    endcase
    if (eof) begin
      r = '{pcm: 16'h0, code: ST_OK, rate: m_rate, chans: m_chans[15:0], st: 1'b1};
      if (m_total < MIN_FILE_BYTES) r.code = ST_SHORT;
      else if (!m_tags_ok) r.code = ST_TAGS;
      else if (m_order_err) r.code = ST_ORDER;
      else if (!m_data_done) r.code = ST_NO_DATA;
      else if (m_chans != 1 && m_chans != 2) r.code = ST_CHANS;
      else if (m_fmt != FMT_PCM && m_fmt != FMT_FLOAT) r.code = ST_FORMAT;
      else if (model_width() == 0) r.code = ST_BITS;
      expected_beats.insert(expected_beats.size(), r);
      parser_clear();
    end
  endtask

  // file building
  task automatic put8(logic [7:0] b);
    byte_item_t it;
    it = '{b: b, eof: 1'b0, typed: 1'b0, exp_beat: '{default: '0}};
    file_bytes.insert(file_bytes.size(), it);
  endtask

  task automatic put16(logic [15:0] v);
    put8(v[7:0]);
    put8(v[15:8]);
  endtask

  task automatic put32(logic [31:0] v);
    put16(v[15:0]);
    put16(v[31:16]);
  endtask

  function automatic logic [31:0] pick_float();
    case ($urandom_range(0, 11))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7F80_0000;
      3: return 32'hFF80_0000;
      4: return 32'h7FC0_0001 | $urandom_range(0, 255);
      5: return 32'h0000_0001;
      6: return 32'h3F80_0000;
      7: return 32'hBF80_0000;
      8: return {1'($urandom_range(0, 1)), 8'($urandom_range(8'h60, 8'h82)), 23'($urandom)};
      9: return {1'($urandom_range(0, 1)), 8'h3F, 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // data chunk of n samples; extra bytes are counted in the length and sent when complete
  task automatic put_data(int w, int n, bit fl, int extra, bit complete);
    int unsigned len;
    len = n * w + extra;
    put32(TAG_DATA);
    put32(len);
    for (int i = 0; i < n; i++) begin
      if (fl) put32(pick_float());
      else for (int k = 0; k < w; k++) put8(8'($urandom));
    end
    if (complete) begin
      for (int k = 0; k < extra; k++) put8(8'($urandom));
      if (len[0]) put8(8'($urandom));
    end
  endtask

  task automatic put_fmt(int unsigned len, logic [15:0] tag, logic [15:0] chans,
                         logic [15:0] bits, logic [15:0] subtag);
    put32(TAG_FMT);
    put32(len);
    put16(tag);
    put16(chans);
    put32($urandom);
    put32($urandom);
    put16(16'($urandom));
    put16(bits);
    for (int p = 16; p < len; p++) begin
      if (p == 24) put8(subtag[7:0]);
      else if (p == 25) put8(subtag[15:8]);
      else put8(8'($urandom));
    end
    if (len[0]) put8(8'($urandom));
  endtask

  task automatic build_file(file_kind_t kind);
    int          w, n;
    bit          fl;
    logic [15:0] tag, bits, chans, sub;
    n = $urandom_range(1, 8);
    chans = 16'($urandom_range(1, 2));
    sub = 16'h0;
    fl = 1'b0;
    case (kind)
      K_PCM8:  begin tag = FMT_PCM; bits = 16'd8; end
      K_PCM24: begin tag = FMT_PCM; bits = 16'd24; end
      K_PCM32: begin tag = FMT_PCM; bits = 16'd32; end
      K_FLOAT: begin tag = FMT_FLOAT; bits = 16'd32; fl = 1'b1; end
      K_EXT: begin
        tag = FMT_EXTENSIBLE;
        fl = 1'($urandom_range(0, 1));
        sub = fl ? FMT_FLOAT : FMT_PCM;
        bits = fl ? 16'd32 : 16'(16 << $urandom_range(0, 1));
      end
      K_BAD_FIELDS: begin
        chans = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3));
        tag = $urandom_range(0, 2) == 0 ? 16'($urandom) : 16'($urandom_range(1, 3));
        bits = $urandom_range(0, 2) == 0 ? 16'($urandom) : 16'(8 * $urandom_range(0, 5));
      end
      default: begin tag = FMT_PCM; bits = 16'd16; end
    endcase
    w = (bits == 8 || bits == 16 || bits == 24 || bits == 32) ? int'(bits / 16'd8) : 2;

    if (kind == K_NOISE) begin
      repeat ($urandom_range(1, 60)) put8(8'($urandom));
    end else begin
      put32(kind == K_BAD_TAGS && $urandom_range(0, 1) ? TAG_RIFF ^ (1 << $urandom_range(0, 31))
                                                       : TAG_RIFF);
      put32($urandom);
      put32(kind == K_BAD_TAGS && $urandom_range(0, 1) ? TAG_WAVE ^ (1 << $urandom_range(0, 31))
                                                       : TAG_WAVE);
      if (kind == K_DATA_FIRST) put_data(w, n, fl, 0, 1'b1);
      if (kind == K_FMT_SHORT)
        put_fmt($urandom_range(0, 15), 16'($urandom), 16'($urandom), 16'($urandom), 16'h0);
      if (kind == K_PAD_PARTIAL) begin
        put32(32'h5453_494C);
        put32(2 * $urandom_range(0, 3) + 1);
        repeat (file_bytes[file_bytes.size() - 4].b) put8(8'($urandom));
        put8(8'($urandom));
      end
      put_fmt(kind == K_EXT ? 40 : 16 + $urandom_range(0, 1) * ($urandom_range(1, 26)),
              tag, chans, bits, sub);
      if (kind == K_TRUNC) put_data(w, n, fl, $urandom_range(1, 8), 1'b0);
      else if (kind == K_PAD_PARTIAL) put_data(w, n, fl, $urandom_range(0, w - 1), 1'b1);
      else put_data(w, n, fl, 0, 1'b1);
      if (kind == K_DATA_TWICE) put_data(w, n, fl, 0, 1'b1);
      if (kind == K_FMT_LATE)
        put_fmt(16, 16'($urandom), 16'($urandom), 16'($urandom), 16'h0);
    end
    file_bytes[file_bytes.size() - 1].eof = 1'b1;
  endtask

  // directed rows: short files whose status is known at a glance
  localparam int N_ROWS = 8;
  byte_item_t dir_rows[N_ROWS];
  initial begin
    dir_rows[0] = '{8'h00, 1'b1, 1'b1, '{16'h0, ST_SHORT, 32'h0, 16'h0, 1'b1}};
    dir_rows[1] = '{8'hFF, 1'b1, 1'b1, '{16'h0, ST_SHORT, 32'h0, 16'h0, 1'b1}};
    dir_rows[2] = '{8'h52, 1'b0, 1'b0, '{default: '0}};
    dir_rows[3] = '{8'h49, 1'b0, 1'b0, '{default: '0}};
    dir_rows[4] = '{8'h46, 1'b0, 1'b0, '{default: '0}};
    dir_rows[5] = '{8'h46, 1'b1, 1'b1, '{16'h0, ST_SHORT, 32'h0, 16'h0, 1'b1}};
    dir_rows[6] = '{8'hAA, 1'b0, 1'b0, '{default: '0}};
    dir_rows[7] = '{8'h55, 1'b1, 1'b1, '{16'h0, ST_SHORT, 32'h0, 16'h0, 1'b1}};
  end

  // sender: reset, directed rows, then whole files with random content
  initial begin
    int         gap;
    byte_item_t it;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'h0;
    end_of_file = 1'b0;
    row_typed = 1'b0;
    row_beat = '{default: '0};
    sent_count = 0;
    hold_req = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    for (int i = 0; i < N_ROWS; i++) file_bytes.insert(file_bytes.size(), dir_rows[i]);
    for (file_kind_t k = K_PCM8; k < K_NUM_KINDS; k = file_kind_t'(k + 1)) build_file(k);
    while (file_bytes.size() < N_ITEMS)
      build_file(file_kind_t'($urandom_range(0, K_NUM_KINDS - 1)));
    while (file_bytes.size() > 0) begin
      it = file_bytes.pop_front();
      if (sent_count == HOLD_AT) hold_req = 1'b1;
      gap = ((sent_count / 50) % 4 == 0 || (hold_req && !hold_done)) ? 0
            : $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid = 1'b1;
      data_byte = it.b;
      end_of_file = it.eof;
      row_typed = it.typed;
      row_beat = it.exp_beat;
      do @(posedge clk); while (!(in_valid && !in_stall));
      sent_count++;
      @(negedge clk);
    end
    in_valid = 1'b0;
    while (expected_beats.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // receiver: random stalls plus one long hold-off to fill the queue
  initial begin
    int gap;
    int beats;
    out_stall = 1'b1;
    hold_done = 1'b0;
    beats = 0;
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall = 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        hold_done = 1'b1;
      end
      gap = ((beats / 40) % 4 == 1) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      beats++;
      @(negedge clk);
    end
  end

  // scoreboard and watchdog
  initial begin
    parser_clear();
    mismatches = 0;
    idle_cycles = 0;
  end

  always @(posedge clk) begin
    beat_t exp_b;
    int    n_before;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected beat: pcm %h code %0d st %b", pcm_sample, status_code,
                     is_status);
        end else begin
          exp_b = expected_beats.pop_front();
          if (pcm_sample !== exp_b.pcm || status_code !== exp_b.code ||
              rate_hz !== exp_b.rate || channel_count !== exp_b.chans ||
              is_status !== exp_b.st) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("mismatch: exp pcm %h code %0d rate %h ch %h st %b / got %h %0d %h %h %b",
                       exp_b.pcm, exp_b.code, exp_b.rate, exp_b.chans, exp_b.st,
                       pcm_sample, status_code, rate_hz, channel_count, is_status);
          end
        end
      end
      if (in_valid && !in_stall) begin
        n_before = expected_beats.size();
        parse_wav_byte(data_byte, end_of_file);
        // typed rows replace the model's status with the value read off by hand
        if (row_typed && expected_beats.size() > n_before)
          expected_beats[expected_beats.size() - 1] = row_beat;
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_MAX) begin
        $display("watchdog: no beat for %0d cycles", WDOG_MAX);
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
